/* design/stpf_pkg.sv */
`default_nettype none

package stpf_pkg;

  // code points that the classifier tells apart
  localparam logic [20:0] CP_Q       = 21'h000071;
  localparam logic [20:0] CP_G       = 21'h000067;
  localparam logic [20:0] CP_A       = 21'h000061;
  localparam logic [20:0] CP_E       = 21'h000065;
  localparam logic [20:0] CP_I       = 21'h000069;
  localparam logic [20:0] CP_O       = 21'h00006F;
  localparam logic [20:0] CP_U       = 21'h000075;
  localparam logic [20:0] CP_Y       = 21'h000079;
  localparam logic [20:0] CP_O_HORN  = 21'h0001A1;
  localparam logic [20:0] CP_E_CIRC  = 21'h0000EA;
  localparam logic [20:0] CP_A_BREVE = 21'h000103;
  localparam logic [20:0] CP_A_CIRC  = 21'h0000E2;
  localparam logic [20:0] CP_O_CIRC  = 21'h0000F4;
  localparam logic [20:0] CP_U_HORN  = 21'h0001B0;

  // character class kept in the store instead of the full code point
  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_Q,
    CLS_G,
    CLS_A,
    CLS_E,
    CLS_I,
    CLS_O,
    CLS_U,
    CLS_Y,
    CLS_OHORN,
    CLS_ECIRC,
    CLS_MARK
  } cls_e;

  // datapath action selected by the control word
  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_INIT,
    ACT_SCAN_CONS,
    ACT_SCAN_VOW,
    ACT_ADJUST,
    ACT_SCAN_NUC,
    ACT_EMIT
  } act_e;

  localparam int StepW = 3;
  typedef logic [StepW-1:0] step_t;

  localparam step_t STEP_IDLE      = 3'd0;
  localparam step_t STEP_INIT      = 3'd1;
  localparam step_t STEP_SCAN_CONS = 3'd2;
  localparam step_t STEP_SCAN_VOW  = 3'd3;
  localparam step_t STEP_ADJUST    = 3'd4;
  localparam step_t STEP_SCAN_NUC  = 3'd5;
  localparam step_t STEP_EMIT      = 3'd6;

  // control word: stay while the datapath asks for more, else jump or fall through
  typedef struct packed {
    act_e  act;
    logic  loop;
    logic  jmp;
    step_t tgt;
  } ctrl_t;

  // status from the datapath back to the sequencer
  typedef struct packed {
    logic more;
  } dp_stat_t;

  function automatic cls_e classify(input logic [20:0] cp);
    cls_e c;
    case (cp)
      CP_Q:       c = CLS_Q;
      CP_G:       c = CLS_G;
      CP_A:       c = CLS_A;
      CP_E:       c = CLS_E;
      CP_I:       c = CLS_I;
      CP_O:       c = CLS_O;
      CP_U:       c = CLS_U;
      CP_Y:       c = CLS_Y;
      CP_O_HORN:  c = CLS_OHORN;
      CP_E_CIRC:  c = CLS_ECIRC;
      CP_A_BREVE: c = CLS_MARK;
      CP_A_CIRC:  c = CLS_MARK;
      CP_O_CIRC:  c = CLS_MARK;
      CP_U_HORN:  c = CLS_MARK;
      default:    c = CLS_OTHER;
    endcase
    return c;
  endfunction

  function automatic logic vowel_class(input cls_e c);
    return !(c == CLS_OTHER || c == CLS_Q || c == CLS_G);
  endfunction

  // microprogram
  function automatic ctrl_t prog_word(input step_t s);
    ctrl_t w;
    case (s)
      STEP_IDLE:      w = '{act: ACT_IDLE,      loop: 1'b1, jmp: 1'b0, tgt: STEP_IDLE};
      STEP_INIT:      w = '{act: ACT_INIT,      loop: 1'b0, jmp: 1'b0, tgt: STEP_IDLE};
      STEP_SCAN_CONS: w = '{act: ACT_SCAN_CONS, loop: 1'b1, jmp: 1'b0, tgt: STEP_IDLE};
      STEP_SCAN_VOW:  w = '{act: ACT_SCAN_VOW,  loop: 1'b1, jmp: 1'b0, tgt: STEP_IDLE};
      STEP_ADJUST:    w = '{act: ACT_ADJUST,    loop: 1'b0, jmp: 1'b0, tgt: STEP_IDLE};
      STEP_SCAN_NUC:  w = '{act: ACT_SCAN_NUC,  loop: 1'b1, jmp: 1'b0, tgt: STEP_IDLE};
      STEP_EMIT:      w = '{act: ACT_EMIT,      loop: 1'b1, jmp: 1'b1, tgt: STEP_IDLE};
      default:        w = '{act: ACT_IDLE,      loop: 1'b0, jmp: 1'b1, tgt: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/stpf_in_if.sv */
`default_nettype none

interface stpf_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        last;

  modport source (output valid, output code_point, output last, input ready);
  modport sink (input valid, input code_point, input last, output ready);
endinterface

`default_nettype wire

/* design/stpf_out_if.sv */
`default_nettype none

interface stpf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] tone_index;
  logic       has_nucleus;
  logic [3:0] nucleus_first;
  logic [3:0] nucleus_length;
  logic       overflow;

  modport source (output valid, output tone_index, output has_nucleus,
                  output nucleus_first, output nucleus_length, output overflow,
                  input ready);
  modport sink (input valid, input tone_index, input has_nucleus,
                input nucleus_first, input nucleus_length, input overflow,
                output ready);
endinterface

`default_nettype wire

/* design/stpf_seq.sv */
`default_nettype none

module stpf_seq import stpf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire dp_stat_t stat_i,
  output ctrl_t         ctrl_o
);

  step_t step_q, step_d;

  // control word lookup
  assign ctrl_o = prog_word(step_q);

  // next step: hold in a loop, else jump or fall through
  always_comb begin
    if (ctrl_o.loop && stat_i.more) begin
      step_d = step_q;
    end else if (ctrl_o.jmp) begin
      step_d = ctrl_o.tgt;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

/* design/stpf_dp.sv */
`default_nettype none

module stpf_dp import stpf_pkg::*; #(
  parameter int MAX_LEN = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire ctrl_t  ctrl_i,
  output dp_stat_t    stat_o,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_data_i,
  stpf_in_if.sink     in_i,
  stpf_out_if.source  out_o
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int IW = $clog2(MAX_LEN);
  localparam logic [CW-1:0] LenC = CW'(MAX_LEN);
  localparam logic [CW-1:0] One  = CW'(1);
  localparam logic [CW-1:0] Two  = CW'(2);
  localparam logic [CW-1:0] Three = CW'(3);

  // class store, written at the fill count, read at the scan pointer
  cls_e mem_q [MAX_LEN];

  logic          rule_q;
  logic [CW-1:0] cnt_q;
  logic          too_long_q;
  logic          out_valid_q;

  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] nf_q;
  logic [CW-1:0] ne_q;
  cls_e          rd_q;
  cls_e          prev_q, first_q, c0_q, c1_q;
  logic          fo_q, fe_q, fm_q;
  logic [CW-1:0] to_q, te_q, tm_q;

  logic [2:0]    tone_idx_q;
  logic          has_q;
  logic [3:0]    first_out_q;
  logic [3:0]    len_out_q;
  logic          ovf_q;

  logic          in_acc;
  logic          out_acc;
  logic          cons_go, vow_go, nuc_go;
  logic          adj;
  logic [CW-1:0] nf_adj;
  logic [CW-1:0] len_w;
  logic [CW-1:0] k_w;
  logic          modern_pair;
  logic [CW-1:0] tone_w;
  logic          emit_go;
  logic [CW+3:0] nf_ext, len_ext, tone_ext;

  assign in_i.ready = (ctrl_i.act == ACT_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_valid_q && out_o.ready;

  // loop conditions of the scans
  assign cons_go = (ptr_q < cnt_q) && !vowel_class(rd_q);
  assign vow_go  = (ptr_q < cnt_q) && vowel_class(rd_q);
  assign nuc_go  = (ptr_q < ne_q);
  assign k_w     = ptr_q - nf_q;

  // qu always, gi only with two or more vowels after the g
  assign adj    = (prev_q == CLS_Q && first_q == CLS_U) ||
                  (prev_q == CLS_G && first_q == CLS_I && (ne_q - nf_q) >= Two);
  assign nf_adj = adj ? nf_q + One : nf_q;

  // next scan pointer
  always_comb begin
    ptr_d = ptr_q;
    case (ctrl_i.act)
      ACT_INIT: begin
        ptr_d = '0;
      end
      ACT_SCAN_CONS: begin
        if (cons_go) begin
          ptr_d = ptr_q + One;
        end
      end
      ACT_SCAN_VOW: begin
        if (vow_go) begin
          ptr_d = ptr_q + One;
        end
      end
      ACT_ADJUST: begin
        ptr_d = nf_adj;
      end
      ACT_SCAN_NUC: begin
        if (nuc_go) begin
          ptr_d = ptr_q + One;
        end
      end
      default: begin
        ptr_d = ptr_q;
      end
    endcase
  end

  // registered read port, addressed by the next scan pointer
  always_ff @(posedge clk_i) begin
    if (ptr_d < LenC) begin
      rd_q <= mem_q[ptr_d[IW-1:0]];
    end else begin
      rd_q <= CLS_OTHER;
    end
  end

  // tone placement rules in order
  assign len_w       = ne_q - nf_q;
  assign modern_pair = (c0_q == CLS_O && c1_q == CLS_A) ||
                       (c0_q == CLS_O && c1_q == CLS_E) ||
                       (c0_q == CLS_U && c1_q == CLS_Y);
  always_comb begin
    if (len_w == '0) begin
      tone_w = '0;
    end else if (fo_q) begin
      tone_w = to_q;
    end else if (fe_q) begin
      tone_w = te_q;
    end else if (fm_q) begin
      tone_w = tm_q;
    end else if (len_w == One) begin
      tone_w = nf_q;
    end else if (rule_q && len_w == Two && ne_q == cnt_q && modern_pair) begin
      tone_w = nf_q + One;
    end else if (ne_q < cnt_q) begin
      tone_w = ne_q - One;
    end else if (len_w == Three) begin
      tone_w = nf_q + One;
    end else begin
      tone_w = nf_q;
    end
  end

  assign nf_ext   = (CW+4)'(nf_q);
  assign len_ext  = (CW+4)'(len_w);
  assign tone_ext = (CW+4)'(tone_w);

  // result register free or being taken this cycle
  assign emit_go = !out_valid_q || out_o.ready;

  // status back to the sequencer
  always_comb begin
    case (ctrl_i.act)
      ACT_IDLE:      stat_o.more = !(in_acc && in_i.last);
      ACT_SCAN_CONS: stat_o.more = cons_go;
      ACT_SCAN_VOW:  stat_o.more = vow_go;
      ACT_SCAN_NUC:  stat_o.more = nuc_go;
      ACT_EMIT:      stat_o.more = !emit_go;
      default:       stat_o.more = 1'b0;
    endcase
  end

  // store write
  always_ff @(posedge clk_i) begin
    if (in_acc && cnt_q < LenC) begin
      mem_q[cnt_q[IW-1:0]] <= classify(in_i.code_point);
    end
  end

  // control state: rule, fill count, overflow flag, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q      <= 1'b0;
      cnt_q       <= '0;
      too_long_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rule_q <= cfg_data_i;
      end
      if (in_acc) begin
        if (cnt_q < LenC) begin
          cnt_q <= cnt_q + One;
        end else begin
          too_long_q <= 1'b1;
        end
      end
      if (ctrl_i.act == ACT_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
        too_long_q  <= 1'b0;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    case (ctrl_i.act)
      ACT_INIT: begin
        prev_q <= CLS_OTHER;
        fo_q   <= 1'b0;
        fe_q   <= 1'b0;
        fm_q   <= 1'b0;
        c0_q   <= CLS_OTHER;
        c1_q   <= CLS_OTHER;
      end
      ACT_SCAN_CONS: begin
        if (cons_go) begin
          prev_q <= rd_q;
        end else begin
          nf_q    <= ptr_q;
          first_q <= (ptr_q < cnt_q) ? rd_q : CLS_OTHER;
        end
      end
      ACT_SCAN_VOW: begin
        if (!vow_go) begin
          ne_q <= ptr_q;
        end
      end
      ACT_ADJUST: begin
        nf_q <= nf_adj;
      end
      ACT_SCAN_NUC: begin
        if (nuc_go) begin
          if (rd_q == CLS_OHORN && !fo_q) begin
            fo_q <= 1'b1;
            to_q <= ptr_q;
          end
          if (rd_q == CLS_ECIRC && !fe_q) begin
            fe_q <= 1'b1;
            te_q <= ptr_q;
          end
          if (rd_q == CLS_MARK && !fm_q) begin
            fm_q <= 1'b1;
            tm_q <= ptr_q;
          end
          if (k_w == '0) begin
            c0_q <= rd_q;
          end
          if (k_w == One) begin
            c1_q <= rd_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.act == ACT_EMIT && emit_go) begin
      if (too_long_q) begin
        tone_idx_q  <= '0;
        has_q       <= 1'b0;
        first_out_q <= '0;
        len_out_q   <= '0;
        ovf_q       <= 1'b1;
      end else begin
        tone_idx_q  <= tone_ext[2:0];
        has_q       <= (len_w != '0);
        first_out_q <= nf_ext[3:0];
        len_out_q   <= len_ext[3:0];
        ovf_q       <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.tone_index     = tone_idx_q;
  assign out_o.has_nucleus    = has_q;
  assign out_o.nucleus_first  = first_out_q;
  assign out_o.nucleus_length = len_out_q;
  assign out_o.overflow       = ovf_q;

  // fill count stays within the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LenC)
    else $error("fill count beyond store depth");

  // nucleus scan never runs past the syllable
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == ACT_SCAN_NUC) |-> (ptr_q <= ne_q && ne_q <= cnt_q && nf_q <= ne_q))
    else $error("nucleus scan out of range");

  // a result is loaded when the register is free or being taken, and then shows as valid
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == ACT_EMIT && emit_go) |=> out_valid_q)
    else $error("emitted result not valid");

  // no item is taken while the syllable is being analysed
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act != ACT_IDLE) |-> !in_acc)
    else $error("item accepted while busy");

endmodule

`default_nettype wire

/* design/syllable_tone_position_finder_core.sv */
// operation: each item is stored at the fill count while the store has room; after the last
//   item of a syllable the sequencer steps through init, the consonant scan, the vowel scan,
//   the qu/gi adjust, the nucleus scan and emit, which waits for a free result register
// throughput: one item per cycle while buffering; the analysis holds the input until the
//   result is loaded, set by the single read port of the store scanned one entry a step
// reset: asynchronous, active low; clears sequencer step, fill count, overflow flag, tone rule and result valid
`default_nettype none

module syllable_tone_position_finder_core import stpf_pkg::*; #(
  parameter int MAX_LEN = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_data_i,
  stpf_in_if.sink    in_i,
  stpf_out_if.source out_o
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  // microprogram sequencer
  stpf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // store, scan datapath and result register
  stpf_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
